// ===== hw/rtl/lsmb_pkg.sv =====
// ----------------------------------------------------------------------------
// lsmb_pkg
// Shared types and codes for the LIFO stack with max-to-bottom reorder.
// ----------------------------------------------------------------------------
package lsmb_pkg;

   // default stack depth
   localparam int DEPTH_DEF = 128;

   // field widths
   localparam int WORD_W = 32;
   localparam int OP_W   = 2;
   localparam int ST_W   = 2;

   // command codes
   localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
   localparam logic [OP_W-1:0] OP_POP     = 2'd1;
   localparam logic [OP_W-1:0] OP_REORDER = 2'd2;

   // status codes
   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

   typedef logic signed [WORD_W-1:0] word_type;

   // result of the shared compare unit
   typedef struct packed {
      logic gt;   // a > b, signed
      logic eq;   // a == b
   } cmp_res_type;

endpackage

// ===== hw/rtl/lsmb_store.sv =====
// ----------------------------------------------------------------------------
// lsmb_store
// Stack storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lsmb_store
   import lsmb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  word_type      wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output word_type      rd_data
);

   word_type mem_ff [DEPTH];
   word_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/lsmb_cmp.sv =====
// ----------------------------------------------------------------------------
// lsmb_cmp
// Shared signed compare unit: greater-than for the max scan, equality for
// the move pass.
// ----------------------------------------------------------------------------
module lsmb_cmp
   import lsmb_pkg::*;
(
   input  word_type    a,
   input  word_type    b,
   output cmp_res_type res
);

   // signed compare and equality
   always_comb begin
      res.gt = (a > b);
      res.eq = (a == b);
   end

endmodule

// ===== hw/rtl/lifo_stack_with_max_to_bottom_unit.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_max_to_bottom_unit
// Bounded LIFO of signed words with push, pop and max-to-bottom reorder.
// Push, failed pop, empty reorder, unused code: result in the cycle after
//    accept. Pop: registered store read, then the response register.
// Reorder: max scan, move pass, then fill of the bottom slots, paced by
//    the one read and one write port of the store and the one shared compare unit.
// Not ready while a command is in progress or a response is held unaccepted.
//    Reset empties the stack (count zero); store contents are not cleared.
// ----------------------------------------------------------------------------
module lifo_stack_with_max_to_bottom_unit
   import lsmb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] push_value
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] popped_value
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_POP  = 3'd1;
   localparam logic [2:0] S_MAX  = 3'd2;
   localparam logic [2:0] S_MOVE = 3'd3;
   localparam logic [2:0] S_FILL = 3'd4;

   logic [2:0]      state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   k_ff, k_in;
   logic [AW-1:0]   w_ff, w_in;
   word_type        max_ff, max_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0] rsp_status_ff, rsp_status_in;
   word_type        rsp_data_ff, rsp_data_in;

   logic            req_fire;
   logic [OP_W-1:0] req_op;
   word_type        req_value;
   logic [CW-1:0]   cnt_m1;
   logic [CW-1:0]   mv_idx;
   logic            k_done;

   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   word_type        wr_data;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   word_type        rd_data;
   cmp_res_type     cmp_res;

   // storage
   lsmb_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared compare unit: store data against the running maximum
   lsmb_cmp u_cmp (
      .a   (rd_data),
      .b   (max_ff),
      .res (cmp_res)
   );

   // handshake and derived values
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = req_tuser[OP_W-1:0];
   assign req_value  = req_tdata[WORD_W-1:0];
   assign cnt_m1     = count_ff - CW'(1);
   assign mv_idx     = cnt_m1 - k_ff;
   assign k_done     = (k_ff == count_ff);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      w_in          = w_ff;
      max_in        = max_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = w_ff;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = k_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        rsp_status_in = ST_OK;
                        wr_en         = 1'b1;
                        wr_addr       = count_ff[AW-1:0];
                        wr_data       = req_value;
                        count_in      = count_ff + CW'(1);
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_data_in   = '0;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = cnt_m1[AW-1:0];
                        count_in = cnt_m1;
                        state_in = S_POP;
                     end
                  end
                  OP_REORDER: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_OK;
                        rsp_data_in   = '0;
                     end else begin
                        k_in     = '0;
                        state_in = S_MAX;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_data_in   = '0;
                  end
               endcase
            end
         end
         S_POP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_data_in   = rd_data;
            state_in      = S_IDLE;
         end
         // bottom to top: read entry k, compare entry k-1
         S_MAX: begin
            rd_en   = !k_done;
            rd_addr = k_ff[AW-1:0];
            if (k_ff != '0) begin
               if (k_ff == CW'(1) || cmp_res.gt) begin
                  max_in = rd_data;
               end
            end
            if (k_done) begin
               k_in     = '0;
               w_in     = cnt_m1[AW-1:0];
               state_in = S_MOVE;
            end else begin
               k_in = k_ff + CW'(1);
            end
         end
         // top to bottom: pack non-max entries upward, keeping order
         S_MOVE: begin
            rd_en   = !k_done;
            rd_addr = mv_idx[AW-1:0];
            if (k_ff != '0 && !cmp_res.eq) begin
               wr_en   = 1'b1;
               wr_addr = w_ff;
               wr_data = rd_data;
               w_in    = w_ff - AW'(1);
            end
            if (k_done) begin
               state_in = S_FILL;
            end else begin
               k_in = k_ff + CW'(1);
            end
         end
         // fill the bottom slots with the maximum
         S_FILL: begin
            wr_en   = 1'b1;
            wr_addr = w_ff;
            wr_data = max_ff;
            if (w_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_data_in   = '0;
               state_in      = S_IDLE;
            end else begin
               w_in = w_ff - AW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      w_ff          <= w_in;
      max_ff        <= max_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // response port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
